// File: hdl/pefc_pkg.sv
// Shared types and constants for the pad edge filter and cursor block.
`timescale 1ns / 1ps

package pefc_pkg;

    // Button vector layout.
    localparam int BTN_W     = 11;
    localparam int BTN_UP    = 7;
    localparam int BTN_DOWN  = 8;
    localparam int BTN_LEFT  = 9;
    localparam int BTN_RIGHT = 10;

    // Cursor step register width.
    localparam int STEP_W = 15;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y     = 3'd7;

    // Mode register bits.
    localparam int MODE_EMU  = 0;
    localparam int MODE_WRAP = 1;

    // Reset values of the bound registers.
    localparam int MIN_X_RST = 0;
    localparam int MAX_X_RST = 319;
    localparam int MIN_Y_RST = 0;
    localparam int MAX_Y_RST = 239;

    typedef logic [BTN_W-1:0] t_btn;

    // Control settings that travel from the register file to the datapath.
    typedef struct packed {
        t_btn edge_mask;
        logic emu_en;
        logic wrap;
    } t_ctl;

endpackage

// File: hdl/pefc_regs.sv
// Configuration register file for the pad edge filter and cursor block.
`timescale 1ns / 1ps

module pefc_regs
    import pefc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_ctl                  o_ctl,
    output logic [STEP_W-1:0]     o_step_x,
    output logic [STEP_W-1:0]     o_step_y,
    output logic [COORD_BITS-1:0] o_min_x,
    output logic [COORD_BITS-1:0] o_max_x,
    output logic [COORD_BITS-1:0] o_min_y,
    output logic [COORD_BITS-1:0] o_max_y
);

    t_btn                  r_edge_mask;
    logic [1:0]            r_mode;
    logic [STEP_W-1:0]     r_step_x;
    logic [STEP_W-1:0]     r_step_y;
    logic [COORD_BITS-1:0] r_min_x;
    logic [COORD_BITS-1:0] r_max_x;
    logic [COORD_BITS-1:0] r_min_y;
    logic [COORD_BITS-1:0] r_max_y;

    // Register writes keep only the low bits that fit each register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_mask <= '0;
            r_mode      <= '0;
            r_step_x    <= STEP_W'(1);
            r_step_y    <= STEP_W'(1);
            r_min_x     <= COORD_BITS'(MIN_X_RST);
            r_max_x     <= COORD_BITS'(MAX_X_RST);
            r_min_y     <= COORD_BITS'(MIN_Y_RST);
            r_max_y     <= COORD_BITS'(MAX_Y_RST);
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_EDGE_MASK: r_edge_mask <= i_wr_data[BTN_W-1:0];
                CFG_MODE:      r_mode      <= i_wr_data[1:0];
                CFG_STEP_X:    r_step_x    <= i_wr_data[STEP_W-1:0];
                CFG_STEP_Y:    r_step_y    <= i_wr_data[STEP_W-1:0];
                CFG_MIN_X:     r_min_x     <= i_wr_data[COORD_BITS-1:0];
                CFG_MAX_X:     r_max_x     <= i_wr_data[COORD_BITS-1:0];
                CFG_MIN_Y:     r_min_y     <= i_wr_data[COORD_BITS-1:0];
                CFG_MAX_Y:     r_max_y     <= i_wr_data[COORD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Present the settings to the datapath.
    assign o_ctl.edge_mask = r_edge_mask;
    assign o_ctl.emu_en    = r_mode[MODE_EMU];
    assign o_ctl.wrap      = r_mode[MODE_WRAP];
    assign o_step_x        = r_step_x;
    assign o_step_y        = r_step_y;
    assign o_min_x         = r_min_x;
    assign o_max_x         = r_max_x;
    assign o_min_y         = r_min_y;
    assign o_max_y         = r_max_y;

endmodule

// File: hdl/pefc_axis.sv
// One cursor axis: signed step, then clamp or wrap at the configured bounds.
`timescale 1ns / 1ps

module pefc_axis
    import pefc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic [COORD_BITS-1:0] i_pos,
    input  logic [STEP_W-1:0]     i_step,
    input  logic                  i_inc,
    input  logic                  i_dec,
    input  logic [COORD_BITS-1:0] i_lo,
    input  logic [COORD_BITS-1:0] i_hi,
    input  logic                  i_wrap,
    output logic [COORD_BITS-1:0] o_next,
    output logic                  o_moving
);

    // Wide enough for any position plus or minus any step, with a sign bit.
    localparam int SUM_W = ((COORD_BITS > STEP_W) ? COORD_BITS : STEP_W) + 2;

    logic signed [SUM_W-1:0] pos_ext;
    logic signed [SUM_W-1:0] lo_ext;
    logic signed [SUM_W-1:0] hi_ext;
    logic signed [SUM_W-1:0] step_ext;
    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] sum;

    // Sign-extend the coordinates and bounds, zero-extend the step.
    assign pos_ext  = {{(SUM_W-COORD_BITS){i_pos[COORD_BITS-1]}}, i_pos};
    assign lo_ext   = {{(SUM_W-COORD_BITS){i_lo[COORD_BITS-1]}}, i_lo};
    assign hi_ext   = {{(SUM_W-COORD_BITS){i_hi[COORD_BITS-1]}}, i_hi};
    assign step_ext = {{(SUM_W-STEP_W){1'b0}}, i_step};

    // The increasing direction takes priority over the decreasing one.
    always_comb begin
        if (i_inc) begin
            delta = step_ext;
        end else if (i_dec) begin
            delta = -step_ext;
        end else begin
            delta = '0;
        end
    end

    assign o_moving = (i_inc || i_dec) && (i_step != '0);
    assign sum      = pos_ext + delta;

    // Above the upper bound is tested first, so inverted bounds need no extra rule.
    always_comb begin
        if (sum > hi_ext) begin
            o_next = i_wrap ? i_lo : i_hi;
        end else if (sum < lo_ext) begin
            o_next = i_wrap ? i_hi : i_lo;
        end else begin
            o_next = sum[COORD_BITS-1:0];
        end
    end

endmodule

// File: hdl/pad_edge_filter_cursor_core.sv
// Top level of the game-pad button edge filter with cursor emulation.
//
//   channel   direction  handshake               payload
//   input     in         i_valid / o_stall       i_raw_buttons
//   result    out        o_valid / i_stall       o_reported_buttons, o_cursor_x,
//                                                o_cursor_y, o_changed
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One poll beat is accepted per cycle while o_stall is low.
// The input register and the result register are parted by one pass of logic.
// The filter and cursor state update in the same cycle the result register loads.
// A stalled result holds while one more beat waits in the input register.
// Synchronous reset restores config, valid flags, filter and cursor state.
`timescale 1ns / 1ps

module pad_edge_filter_cursor_core
    import pefc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BTN_W-1:0]      i_raw_buttons,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [BTN_W-1:0]      o_reported_buttons,
    output logic [COORD_BITS-1:0] o_cursor_x,
    output logic [COORD_BITS-1:0] o_cursor_y,
    output logic                  o_changed,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl                  ctl;
    logic [STEP_W-1:0]     step_x;
    logic [STEP_W-1:0]     step_y;
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_y;

    logic                  r_in_valid;
    t_btn                  r_raw;
    logic                  r_out_valid;
    logic                  r_changed;
    t_btn                  r_prev_raw;
    t_btn                  r_prev_rep;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;

    logic                  out_load;
    logic                  in_accept;
    logic                  process;
    t_btn                  edge_bits;
    t_btn                  rep;
    logic [COORD_BITS-1:0] next_x;
    logic [COORD_BITS-1:0] next_y;
    logic                  moving_x;
    logic                  moving_y;
    logic                  step_taken;
    logic                  n_changed;

    // Config regs; the user must write only while the block is idle; unenforced.
    assign o_cfg_ready = 1'b1;

    pefc_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_ctl      (ctl),
        .o_step_x   (step_x),
        .o_step_y   (step_y),
        .o_min_x    (min_x),
        .o_max_x    (max_x),
        .o_min_y    (min_y),
        .o_max_y    (max_y)
    );

    // Handshake: the result register loads when empty or when its beat leaves.
    assign out_load  = !r_out_valid || !i_stall;
    assign process   = r_in_valid && out_load;
    assign o_stall   = r_in_valid && !out_load;
    assign in_accept = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_raw <= i_raw_buttons;
        end
    end

    // Edge filter: masked buttons report only on a fresh press.
    assign edge_bits = r_raw & ~r_prev_raw;
    assign rep       = (r_raw & ~ctl.edge_mask) | (edge_bits & ctl.edge_mask);

    // Cursor axes; Right beats Left and Down beats Up.
    pefc_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_x (
        .i_pos    (r_pos_x),
        .i_step   (step_x),
        .i_inc    (rep[BTN_RIGHT]),
        .i_dec    (rep[BTN_LEFT]),
        .i_lo     (min_x),
        .i_hi     (max_x),
        .i_wrap   (ctl.wrap),
        .o_next   (next_x),
        .o_moving (moving_x)
    );

    pefc_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_y (
        .i_pos    (r_pos_y),
        .i_step   (step_y),
        .i_inc    (rep[BTN_DOWN]),
        .i_dec    (rep[BTN_UP]),
        .i_lo     (min_y),
        .i_hi     (max_y),
        .i_wrap   (ctl.wrap),
        .o_next   (next_y),
        .o_moving (moving_y)
    );

    // A step on either axis recomputes both axes and always marks a change.
    assign step_taken = ctl.emu_en && (moving_x || moving_y);
    assign n_changed  = step_taken || (rep != r_prev_rep);

    // Result register and filter state; the state doubles as the result payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev_raw  <= '0;
            r_prev_rep  <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (process) begin
                r_prev_raw <= r_raw;
                r_prev_rep <= rep;
                if (step_taken) begin
                    r_pos_x <= next_x;
                    r_pos_y <= next_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_changed <= n_changed;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_reported_buttons = r_prev_rep;
    assign o_cursor_x         = r_pos_x;
    assign o_cursor_y         = r_pos_y;
    assign o_changed          = r_changed;

endmodule

// File: hdl/pefc_checker.sv
// Port-level checks for the pad edge filter and cursor block, bound to the top level.
`timescale 1ns / 1ps

module pefc_checker
    import pefc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [BTN_W-1:0]      o_reported_buttons,
    input logic [COORD_BITS-1:0] o_cursor_x,
    input logic [COORD_BITS-1:0] o_cursor_y,
    input logic                  o_changed
);

    // A result beat held by a stall stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_reported_buttons) && $stable(o_cursor_x)
            && $stable(o_cursor_y) && $stable(o_changed))
        else $error("stalled result payload changed");

    // Input backpressure only appears when a result is waiting and held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // An accepted poll fills the input register, then the result register unless stalled.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall ##1 !i_stall |=> o_valid)
        else $error("accepted poll did not produce a result");

endmodule

bind pad_edge_filter_cursor_core pefc_checker #(
    .COORD_BITS (COORD_BITS)
) u_pefc_checker (.*);
